[rtl/core/bbc_pkg.sv]
// bbc_pkg: shared types and codes for the block buffer cache
// request and response payloads, slot metadata, scan flags and sequencer states
// no dependencies
`default_nettype none

package bbc_pkg;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  device_id;
    logic [31:0] block_number;
    logic [4:0]  slot_in;
  } req_t;

  typedef struct packed {
    logic [4:0] slot_out;
    logic [1:0] status;
    logic       need_disk_read;
    logic       was_hit;
    logic       moved_to_front;
  } rsp_t;

  localparam logic REQ_GET     = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_UNHELD    = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0]  device;
    logic [31:0] block;
    logic        valid;
    logic [7:0]  refcount;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  typedef struct packed {
    logic hit_found;
    logic hit_valid;
    logic hit_sat;
    logic free_found;
  } scan_flags_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_GET_WB,
    S_REL_RD,
    S_REL_CHK,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/core/block_buffer_cache_lru_top.sv]
// block_buffer_cache_lru_top: buffer cache slot tracker with reference counts
// sequencer over bbc_slot_mem and bbc_scan_unit; uses bbc_pkg
`default_nettype none

// After reset the slot memory is swept once to its reset contents, during which
// no request is taken. A get walks every slot through the single read port of
// the slot memory, one entry per cycle, before its result is written back. A
// release that leaves the count above zero, or that names an unheld slot, reads
// and checks only that slot, and one whose slot number is out of range goes
// straight to its result; one that drops the count to zero walks all slots
// again to age their ranks. One request is in work at a time; the next one is
// accepted while the previous result waits in the output register.
module block_buffer_cache_lru_top #(
  parameter int NUM_SLOTS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire bbc_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output bbc_pkg::rsp_t      rsp
);

  import bbc_pkg::*;

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int EW = META_W + IW;
  localparam logic [IW-1:0] TOP_IDX = IW'(NUM_SLOTS - 1);
  localparam logic [CW-1:0] CNT_END = CW'(NUM_SLOTS);

  state_t state;
  state_t state_next;

  logic [CW-1:0] cnt;
  logic          rvalid;
  logic [IW-1:0] ridx;
  logic          issue;
  req_t          req_q;
  rsp_t          res;
  logic [IW-1:0] rel_rank;
  logic [IW-1:0] rel_addr;
  logic          accept;
  logic          in_range;
  logic          rsp_load;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;
  meta_t         rd_meta;
  logic [IW-1:0] rd_rank;
  meta_t         wr_meta;
  logic [IW-1:0] wr_rank;

  logic          scan_start;
  logic          scan_en;
  scan_flags_t   flags;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] hit_rank;
  logic [7:0]    hit_count;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] free_rank;

  assign accept   = req_valid && !req_stall;
  assign in_range = 32'(req.slot_in) < 32'(NUM_SLOTS);
  assign rel_addr = IW'(req_q.slot_in);
  assign rd_meta  = meta_t'(mem_rdata[EW-1:IW]);
  assign rd_rank  = mem_rdata[IW-1:0];
  assign rsp_load = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  bbc_slot_mem #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bbc_scan_unit #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .en        (scan_en),
    .idx       (ridx),
    .meta      (rd_meta),
    .rank      (rd_rank),
    .dev       (req_q.device_id),
    .blk       (req_q.block_number),
    .flags     (flags),
    .hit_idx   (hit_idx),
    .hit_rank  (hit_rank),
    .hit_count (hit_count),
    .free_idx  (free_idx),
    .free_rank (free_rank)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (cnt == CW'(NUM_SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_GET) begin
            state_next = S_SCAN;
          end else if (in_range) begin
            state_next = S_REL_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (rvalid && (ridx == TOP_IDX)) begin
          state_next = S_GET_WB;
        end
      end
      S_GET_WB:  state_next = S_DONE;
      S_REL_RD:  state_next = S_REL_CHK;
      S_REL_CHK: begin
        if (rd_meta.refcount == 8'd1) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        if (rvalid && (ridx == TOP_IDX)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = (state != S_IDLE);
    mem_we     = 1'b0;
    mem_waddr  = ridx;
    mem_raddr  = cnt[IW-1:0];
    issue      = 1'b0;
    scan_start = 1'b0;
    scan_en    = 1'b0;
    wr_meta    = rd_meta;
    wr_rank    = rd_rank;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[IW-1:0];
        wr_meta   = '0;
        wr_rank   = TOP_IDX - cnt[IW-1:0];
      end
      S_IDLE: begin
        scan_start = 1'b1;
      end
      S_SCAN: begin
        issue   = (cnt != CNT_END);
        scan_en = rvalid;
      end
      S_GET_WB: begin
        wr_meta.device = req_q.device_id;
        wr_meta.block  = req_q.block_number;
        wr_meta.valid  = 1'b1;
        if (flags.hit_found) begin
          mem_we           = 1'b1;
          mem_waddr        = hit_idx;
          wr_meta.refcount = flags.hit_sat ? hit_count : hit_count + 8'd1;
          wr_rank          = hit_rank;
        end else begin
          mem_we           = flags.free_found;
          mem_waddr        = free_idx;
          wr_meta.refcount = 8'd1;
          wr_rank          = free_rank;
        end
      end
      S_REL_RD: begin
        mem_raddr = rel_addr;
      end
      S_REL_CHK: begin
        // count stays nonzero: write back the decrement only
        mem_we           = (rd_meta.refcount > 8'd1);
        mem_waddr        = rel_addr;
        wr_meta.refcount = rd_meta.refcount - 8'd1;
      end
      S_SHIFT: begin
        issue  = (cnt != CNT_END);
        mem_we = rvalid;
        if (ridx == rel_addr) begin
          wr_meta.refcount = 8'd0;
          wr_rank          = '0;
        end else if (rd_rank < rel_rank) begin
          wr_rank = rd_rank + IW'(1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
    mem_wdata = {wr_meta, wr_rank};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      rvalid    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rvalid <= issue;
      if (state == S_IDLE || (state == S_CLEAR && state_next != S_CLEAR)) begin
        cnt <= '0;
      end else if (state == S_CLEAR || issue) begin
        cnt <= cnt + CW'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // transaction payload and result assembly
  always_ff @(posedge clk) begin
    ridx <= cnt[IW-1:0];
    if (accept) begin
      req_q <= req;
      if (req.req_type == REQ_RELEASE) begin
        res <= rsp_t'({req.slot_in, in_range ? ST_OK : ST_UNHELD, 3'b000});
      end else begin
        res <= '0;
      end
    end
    if (state == S_GET_WB) begin
      if (flags.hit_found) begin
        res.slot_out       <= 5'(hit_idx);
        res.status         <= flags.hit_sat ? ST_SATURATED : ST_OK;
        res.need_disk_read <= !flags.hit_valid;
        res.was_hit        <= 1'b1;
      end else if (flags.free_found) begin
        res.slot_out       <= 5'(free_idx);
        res.need_disk_read <= 1'b1;
      end else begin
        res.status <= ST_NO_FREE;
      end
    end
    if (state == S_REL_CHK) begin
      rel_rank <= rd_rank;
      if (rd_meta.refcount == 8'd0) begin
        res.status <= ST_UNHELD;
      end else if (rd_meta.refcount == 8'd1) begin
        res.moved_to_front <= 1'b1;
      end
    end
    if (rsp_load) begin
      rsp <= res;
    end
  end

  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while a transaction is in work");

  a_no_free_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_NO_FREE) |->
      (rsp.slot_out == 5'd0 && !rsp.need_disk_read && !rsp.was_hit && !rsp.moved_to_front))
    else $error("no-free result carries nonzero fields");

  a_front_release: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.moved_to_front) |->
      (rsp.status == ST_OK && !rsp.was_hit && !rsp.need_disk_read))
    else $error("move to front on a result that is not a clean release");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("slot memory written while idle");

endmodule

`default_nettype wire

[rtl/core/bbc_slot_mem.sv]
// bbc_slot_mem: per-slot storage for tags, valid, count and rank
// one write port, one read port with registered read data; no package use
`default_nettype none

module bbc_slot_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 54
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/bbc_scan_unit.sv]
// bbc_scan_unit: shared compare unit stepped over one slot entry per cycle
// tracks the lowest-rank tag match and the highest-rank free slot; uses bbc_pkg
`default_nettype none

module bbc_scan_unit #(
  parameter int NUM_SLOTS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic                         en,
  input  wire logic [$clog2(NUM_SLOTS)-1:0] idx,
  input  wire bbc_pkg::meta_t               meta,
  input  wire logic [$clog2(NUM_SLOTS)-1:0] rank,
  input  wire logic [7:0]                   dev,
  input  wire logic [31:0]                  blk,
  output bbc_pkg::scan_flags_t              flags,
  output logic      [$clog2(NUM_SLOTS)-1:0] hit_idx,
  output logic      [$clog2(NUM_SLOTS)-1:0] hit_rank,
  output logic      [7:0]                   hit_count,
  output logic      [$clog2(NUM_SLOTS)-1:0] free_idx,
  output logic      [$clog2(NUM_SLOTS)-1:0] free_rank
);

  import bbc_pkg::*;

  logic hit_found;
  logic hit_valid;
  logic free_found;
  logic match;
  logic take_hit;
  logic take_free;

  assign match     = (meta.device == dev) && (meta.block == blk);
  assign take_hit  = match && (!hit_found || (rank < hit_rank));
  assign take_free = (meta.refcount == 8'd0) && (!free_found || (rank > free_rank));

  always_ff @(posedge clk) begin
    if (rst || start) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (en) begin
      if (take_hit) begin
        hit_found <= 1'b1;
      end
      if (take_free) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && take_hit) begin
      hit_idx   <= idx;
      hit_rank  <= rank;
      hit_count <= meta.refcount;
      hit_valid <= meta.valid;
    end
    if (en && take_free) begin
      free_idx  <= idx;
      free_rank <= rank;
    end
  end

  assign flags.hit_found  = hit_found;
  assign flags.hit_valid  = hit_valid;
  assign flags.hit_sat    = (hit_count == COUNT_MAX);
  assign flags.free_found = free_found;

endmodule

`default_nettype wire

[tb/block_buffer_cache_lru_checker.sv]
// block_buffer_cache_lru_checker: watches both channels of the buffer cache,
// predicts each response from its own copy of the slot tags, counts and ranks
// depends on bbc_pkg
`timescale 1ns / 1ps

module block_buffer_cache_lru_checker #(
  parameter int NUM_SLOTS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  bbc_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  bbc_pkg::rsp_t rsp,
  output int            errors,
  output int            pending
);

  import bbc_pkg::*;

  localparam int RANK_W = $clog2(NUM_SLOTS);

  logic [7:0]        slot_dev  [NUM_SLOTS];
  logic [31:0]       slot_blk  [NUM_SLOTS];
  logic              slot_vld  [NUM_SLOTS];
  logic [7:0]        slot_refs [NUM_SLOTS];
  logic [RANK_W-1:0] slot_rank [NUM_SLOTS];

  rsp_t slot_replies[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic rsp_t serve_request(input req_t r);
    rsp_t              o;
    int                i;
    int                pick;
    bit                found;
    logic [RANK_W-1:0] old_rank;
    o     = '0;
    pick  = 0;
    found = 1'b0;
    if (r.req_type == REQ_GET) begin
      // hit: matching tags, most recent wins; valid bit not part of the match
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (slot_dev[i] == r.device_id && slot_blk[i] == r.block_number &&
            (!found || slot_rank[i] < slot_rank[pick])) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        o.was_hit = 1'b1;
        if (slot_refs[pick] == COUNT_MAX) o.status = ST_SATURATED;
        else slot_refs[pick] = slot_refs[pick] + 8'd1;
      end else begin
        // miss: oldest free slot gets recycled
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (slot_refs[i] == 8'd0 && (!found || slot_rank[i] > slot_rank[pick])) begin
            pick  = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          o.status = ST_NO_FREE;
          return o;
        end
        slot_dev[pick]  = r.device_id;
        slot_blk[pick]  = r.block_number;
        slot_vld[pick]  = 1'b0;
        slot_refs[pick] = 8'd1;
      end
      if (!slot_vld[pick]) begin
        o.need_disk_read = 1'b1;
        slot_vld[pick]   = 1'b1;
      end
      o.slot_out = 5'(pick);
    end else begin
      o.slot_out = r.slot_in;
      if (int'(r.slot_in) >= NUM_SLOTS || slot_refs[r.slot_in] == 8'd0) begin
        o.status = ST_UNHELD;
      end else begin
        slot_refs[r.slot_in] = slot_refs[r.slot_in] - 8'd1;
        if (slot_refs[r.slot_in] == 8'd0) begin
          old_rank = slot_rank[r.slot_in];
          for (i = 0; i < NUM_SLOTS; i++) begin
            if (slot_rank[i] < old_rank) slot_rank[i] = slot_rank[i] + 1'b1;
          end
          slot_rank[r.slot_in] = '0;
          o.moved_to_front     = 1'b1;
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_dev[i]  = '0;
        slot_blk[i]  = '0;
        slot_vld[i]  = 1'b0;
        slot_refs[i] = '0;
        slot_rank[i] = RANK_W'(NUM_SLOTS - 1 - i);
      end
      slot_replies.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (slot_replies.size() == 0) begin
          report_mismatch("unrequested transaction, slot_out", rsp.slot_out, 0);
        end else begin
          want = slot_replies.pop_front();
          if (rsp.slot_out !== want.slot_out)
            report_mismatch("slot_out", rsp.slot_out, want.slot_out);
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
          if (rsp.need_disk_read !== want.need_disk_read)
            report_mismatch("need_disk_read", rsp.need_disk_read, want.need_disk_read);
          if (rsp.was_hit !== want.was_hit)
            report_mismatch("was_hit", rsp.was_hit, want.was_hit);
          if (rsp.moved_to_front !== want.moved_to_front)
            report_mismatch("moved_to_front", rsp.moved_to_front, want.moved_to_front);
        end
      end
      if (req_valid && !req_stall) begin
        slot_replies.push_back(serve_request(req));
      end
    end
    pending = slot_replies.size();
  end

endmodule

[tb/block_buffer_cache_lru_top_tb.sv]
// block_buffer_cache_lru_top_tb: drives gets and releases into the buffer cache
// and gives the verdict; depends on bbc_pkg, block_buffer_cache_lru_top and
// block_buffer_cache_lru_checker
`timescale 1ns / 1ps

module block_buffer_cache_lru_top_tb;
  import bbc_pkg::*;

  localparam int NUM_SLOTS    = 32;
  localparam int RANDOM_ITEMS = 80;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 4000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  int   errors;
  int   pending;

  logic       idle_on  = 1'b1;
  logic       hold_req = 1'b0;
  int         quiet_cycles = 0;
  logic [4:0] held_slots[$];

  block_buffer_cache_lru_top #(.NUM_SLOTS(NUM_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  block_buffer_cache_lru_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // response side: random stall bursts, plus one long hold on request
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // slots granted by gets, so releases can target held slots
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall && (rsp.was_hit || rsp.need_disk_read)) begin
      held_slots.push_back(rsp.slot_out);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t get_req(input logic [7:0] dev, input logic [31:0] blk);
    req_t r;
    r.req_type     = REQ_GET;
    r.device_id    = dev;
    r.block_number = blk;
    r.slot_in      = 5'($urandom);
    return r;
  endfunction

  function automatic req_t release_req(input logic [4:0] slot);
    req_t r;
    r.req_type     = REQ_RELEASE;
    r.device_id    = 8'($urandom);
    r.block_number = $urandom;
    r.slot_in      = slot;
    return r;
  endfunction

  task automatic send(input req_t r);
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic release_held();
    while (held_slots.size() != 0) send(release_req(held_slots.pop_front()));
    drain();
  endtask

  initial begin : stimulus
    logic [7:0]  dev_pool [4];
    logic [31:0] blk_pool [12];
    logic [31:0] sat_blk;
    logic [4:0]  sat_slot;
    logic [4:0]  s;
    int          idx;
    int          phase;
    int          get_pct;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    dev_pool  = '{8'h00, 8'hFF, 8'h01, 8'($urandom)};
    blk_pool[0] = 32'h0000_0000;
    blk_pool[1] = 32'hFFFF_FFFF;
    blk_pool[2] = 32'h8000_0000;
    blk_pool[3] = 32'h0000_0001;
    for (int i = 4; i < 12; i++) blk_pool[i] = $urandom;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners: releases of unheld slots, the all-zero tag match after reset,
    // extreme tags, a count dropping to zero and a hit on a released slot
    send(release_req(5'd0));
    send(get_req(8'h00, 32'h0000_0000));
    send(get_req(8'h00, 32'h0000_0000));
    send(get_req(8'hFF, 32'hFFFF_FFFF));
    send(get_req(8'h00, 32'hFFFF_FFFF));
    send(get_req(8'hFF, 32'h0000_0000));
    send(release_req(5'd31));
    send(release_req(5'd31));
    send(release_req(5'd31));
    send(release_req(5'd0));
    send(get_req(8'hFF, 32'hFFFF_FFFF));
    send(release_req(5'd0));
    send(get_req(8'h00, 32'h0000_0000));
    send(release_req(5'd31));
    send(release_req(5'd1));
    drain();
    held_slots.delete();

    // fill every free slot with fresh tags, then run out of buffers
    for (int i = 0; i < NUM_SLOTS + 3; i++) send(get_req(8'h5A, $urandom));
    drain();
    release_held();

    // push one slot's count to its limit and keep getting it while saturated, then release it twice
    sat_blk = $urandom;
    for (int i = 0; i < 257; i++) send(get_req(8'hC3, sat_blk));
    drain();
    sat_slot = held_slots[$];
    held_slots.delete();
    repeat (2) send(release_req(sat_slot));
    drain();
    held_slots.delete();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      phase   = k / 20;
      idle_on = (phase != 2) && (k < RANDOM_ITEMS - 20);
      if (k == 10) hold_req = 1'b1;
      get_pct = (phase % 3 == 0) ? 85 : (phase % 3 == 1) ? 50 : 25;
      if ($urandom_range(0, 99) < get_pct) begin
        if ($urandom_range(0, 9) == 0) begin
          send(get_req(8'($urandom), $urandom));
        end else begin
          send(get_req(dev_pool[$urandom_range(0, 3)], blk_pool[$urandom_range(0, 11)]));
        end
      end else if (held_slots.size() != 0 && $urandom_range(0, 7) != 0) begin
        idx = $urandom_range(0, held_slots.size() - 1);
        s   = held_slots[idx];
        held_slots.delete(idx);
        send(release_req(s));
      end else begin
        send(release_req(5'($urandom)));
      end
    end

    drain();
    repeat (NUM_SLOTS + 16) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/bbc_pkg.sv
rtl/core/bbc_slot_mem.sv
rtl/core/bbc_scan_unit.sv
rtl/core/block_buffer_cache_lru_top.sv
tb/block_buffer_cache_lru_checker.sv
tb/block_buffer_cache_lru_top_tb.sv
